@@ rtl/prsf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsf_pkg
// Shared types, constants and the segment encoder for the pressure readout
// segment formatter.
// ----------------------------------------------------------------------------
package prsf_pkg;

  typedef enum logic [1:0] {
    MODE_QNH  = 2'd0,
    MODE_QFE  = 2'd1,
    MODE_STD  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam int unsigned FRAME_LEN = 7;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
  localparam int unsigned NUM_POS   = 4;

  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FRAME_LEN - 1);
  localparam logic [15:0]      SAT_LIMIT = 16'd9999;
  localparam logic [7:0]       IND_MASK  = 8'h10;

  localparam logic [3:0] SYM_S     = 4'd5;
  localparam logic [3:0] SYM_T     = 4'd11;
  localparam logic [3:0] SYM_D     = 4'd12;
  localparam logic [3:0] SYM_BLANK = 4'd13;

  // indicator bits for positions 1..3 (dot, QFE, QNH)
  localparam logic [2:0] IND_QNH = 3'b100;
  localparam logic [2:0] IND_QFE = 3'b011;
  localparam logic [2:0] IND_OFF = 3'b000;

  typedef struct packed {
    logic [FRAME_LEN-1:0][7:0] seg;
    logic [FRAME_LEN-1:0][2:0] addr;
  } frame_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] sym);
    logic [7:0] pat;
    case (sym)
      4'd0:    pat = 8'hEB;
      4'd1:    pat = 8'h60;
      4'd2:    pat = 8'hC7;
      4'd3:    pat = 8'hE5;
      4'd4:    pat = 8'h6C;
      4'd5:    pat = 8'hAD;
      4'd6:    pat = 8'hAF;
      4'd7:    pat = 8'hE0;
      4'd8:    pat = 8'hEF;
      4'd9:    pat = 8'hED;
      4'd10:   pat = 8'h04;
      4'd11:   pat = 8'h0F;
      4'd12:   pat = 8'h67;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/prsf_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsf_encoder
// Saturates the value, splits it into decimal digits and builds the seven
// display writes of one request, along with the new indicator bits.
// ----------------------------------------------------------------------------
module prsf_encoder
  import prsf_pkg::*;
(
  input  logic [1:0]  mode_i,
  input  logic [15:0] value_i,
  input  logic [2:0]  ind_i,      // dot, QFE, QNH indicators held now
  output frame_t      frame_o,
  output logic [2:0]  ind_new_o
);

  logic [13:0] v_sat;
  logic [30:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;
  logic [9:0]  q1;
  logic [6:0]  q2;
  logic [3:0]  q3;
  logic [13:0] r_ones;
  logic [9:0]  r_tens;
  logic [6:0]  r_hund;
  logic        is_std;
  logic [NUM_POS-1:0][3:0] sym;
  logic [NUM_POS-1:0] old_ind;
  logic [NUM_POS-1:0] new_ind;

  assign v_sat = (value_i > SAT_LIMIT) ? SAT_LIMIT[13:0] : value_i[13:0];

  // reciprocal multiplies, exact for values up to 9999
  assign prod10   = 31'(v_sat) * 31'd52429;
  assign prod100  = 27'(v_sat) * 27'd5243;
  assign prod1000 = 28'(v_sat) * 28'd8389;
  assign q1 = prod10[28:19];
  assign q2 = prod100[25:19];
  assign q3 = prod1000[26:23];

  assign r_ones = v_sat - 14'({q1, 3'b000}) - 14'({q1, 1'b0});
  assign r_tens = q1 - 10'({q2, 3'b000}) - 10'({q2, 1'b0});
  assign r_hund = q2 - 7'({q3, 3'b000}) - 7'({q3, 1'b0});

  assign is_std = (mode_i == MODE_STD);

  always_comb begin
    if (is_std) begin
      if (value_i == 16'd1) begin
        sym[0] = SYM_S;
        sym[1] = SYM_T;
        sym[2] = SYM_D;
        sym[3] = SYM_BLANK;
      end else begin
        sym[0] = SYM_BLANK;
        sym[1] = SYM_BLANK;
        sym[2] = SYM_BLANK;
        sym[3] = SYM_BLANK;
      end
    end else begin
      sym[0] = q3;
      sym[1] = r_hund[3:0];
      sym[2] = r_tens[3:0];
      sym[3] = r_ones[3:0];
    end
  end

  always_comb begin
    unique case (mode_i)
      MODE_QNH: ind_new_o = IND_QNH;
      MODE_QFE: ind_new_o = IND_QFE;
      default:  ind_new_o = IND_OFF;
    endcase
  end

  // position 0 has no indicator of its own
  assign old_ind = {ind_i, 1'b0};
  assign new_ind = {ind_new_o, 1'b0};

  always_comb begin
    logic [1:0] p;
    for (int k = 0; k < FRAME_LEN; k++) begin
      if (k < NUM_POS) begin
        p = is_std ? 2'(k) : 2'(NUM_POS - 1 - k);
        frame_o.seg[k] = (seg_encode(sym[p]) & ~IND_MASK) | (old_ind[p] ? IND_MASK : 8'h00);
      end else begin
        p = 2'(k - (NUM_POS - 1));
        frame_o.seg[k] = (seg_encode(sym[p]) & ~IND_MASK) | (new_ind[p] ? IND_MASK : 8'h00);
      end
      frame_o.addr[k] = {p, 1'b0};
    end
  end

endmodule

@@ rtl/prsf_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsf_serializer
// Holds one formatted frame and the indicator state, and streams the frame
// out one display write per cycle while m_axis_tready is high.
// ----------------------------------------------------------------------------
module prsf_serializer
  import prsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  frame_t      frame_i,
  input  logic [2:0]  ind_new_i,
  output logic [2:0]  ind_o,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] lcd_address, [10:3] segment_byte
  output logic        m_axis_tlast    // last
);

  frame_t            frm_q;
  logic              frm_valid_q, frm_valid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [2:0]        ind_q;
  logic              out_fire;

  assign out_fire = frm_valid_q && m_axis_tready;
  assign free_o   = !frm_valid_q || (out_fire && cnt_q == CNT_LAST);
  assign ind_o    = ind_q;

  always_comb begin
    frm_valid_d = frm_valid_q;
    cnt_d       = cnt_q;
    if (load_i) begin
      frm_valid_d = 1'b1;
      cnt_d       = '0;
    end else if (out_fire) begin
      if (cnt_q == CNT_LAST) begin
        frm_valid_d = 1'b0;
        cnt_d       = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_valid_q <= 1'b0;
      cnt_q       <= '0;
      ind_q       <= IND_OFF;
    end else begin
      frm_valid_q <= frm_valid_d;
      cnt_q       <= cnt_d;
      if (load_i) begin
        ind_q <= ind_new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frm_q <= frame_i;
    end
  end

  assign m_axis_tvalid = frm_valid_q;
  assign m_axis_tdata  = {5'd0, frm_q.seg[cnt_q], frm_q.addr[cnt_q]};
  assign m_axis_tlast  = (cnt_q == CNT_LAST);

  // a frame is never overwritten before its last write goes out
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!frm_valid_q || (out_fire && cnt_q == CNT_LAST)))
    else $error("frame loaded over a pending frame");

  // once started, a frame runs to its last write
  a_frame_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && cnt_q != CNT_LAST) |=> frm_valid_q)
    else $error("frame cut short");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LAST)
    else $error("write counter out of range");

  // the final write always goes to the QNH indicator position
  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frm_valid_q && m_axis_tlast) |-> (m_axis_tdata[2:0] == 3'd6))
    else $error("last write at wrong address");

endmodule

@@ rtl/pressure_readout_segment_formatter_core.sv @@
`timescale 1ns / 1ps
// A request passes the input register, then the serializer's frame register.
// Throughput: set by the serializer's single write per cycle, held off by
//   m_axis_tready; the next request is taken while the frame streams out.
// Requests with the unused mode are dropped and produce no write.
// Reset clears the valid flags, the write counter and the indicator bits.
// ----------------------------------------------------------------------------
// pressure_readout_segment_formatter_core
// Formats QNH/QFE/STD pressure requests into seven LCD segment writes.
// ----------------------------------------------------------------------------
module pressure_readout_segment_formatter_core
  import prsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] lcd_address, [10:3] segment_byte
  output logic        m_axis_tlast    // last
);

  logic        in_valid_q, in_valid_d;
  logic [1:0]  mode_q;
  logic [15:0] value_q;
  logic        frm_free;
  logic        in_take;
  logic        load;
  logic        in_fire;
  logic [2:0]  ind;
  logic [2:0]  ind_new;
  frame_t      frame;

  assign in_take       = in_valid_q && (mode_q == MODE_NONE || frm_free);
  assign load          = in_valid_q && (mode_q != MODE_NONE) && frm_free;
  assign s_axis_tready = !in_valid_q || in_take;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (in_take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= s_axis_tuser;
      value_q <= s_axis_tdata;
    end
  end

  prsf_encoder u_encoder (
    .mode_i    (mode_q),
    .value_i   (value_q),
    .ind_i     (ind),
    .frame_o   (frame),
    .ind_new_o (ind_new)
  );

  prsf_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .frame_i       (frame),
    .ind_new_i     (ind_new),
    .ind_o         (ind),
    .free_o        (frm_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
